// ===== hdl/bfs_shortest_path_core_assert.svh =====
// Assertion macros for the shortest-path search core and its checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef BFS_SHORTEST_PATH_CORE_ASSERT_SVH
`define BFS_SHORTEST_PATH_CORE_ASSERT_SVH

// same-cycle implication
`define BSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bsp_pkg.sv =====
// Shared types and constants of the shortest-path search core.
// No dependencies.
package bsp_pkg;
	localparam int VTX_W      = 6;   // vertex number width
	localparam int HOP_W      = 5;   // hop count width
	localparam int PATH_LIMIT = 32;  // longest path that can be reported
	localparam int STK_W      = 5;   // path stack index width
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NODE_COUNT = 2'd0,
		REG_START      = 2'd1,
		REG_FINISH     = 2'd2,
		REG_UNUSED     = 2'd3
	} cfg_reg_t;

	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b00000000001,
		ST_DEQ      = 11'b00000000010,
		ST_DEQ_W    = 11'b00000000100,
		ST_SCAN     = 11'b00000001000,
		ST_CHK_FWD  = 11'b00000010000,
		ST_CHK_REV  = 11'b00000100000,
		ST_TRACE_RD = 11'b00001000000,
		ST_TRACE_WR = 11'b00010000000,
		ST_EMIT_RD  = 11'b00100000000,
		ST_EMIT_WR  = 11'b01000000000,
		ST_NOT_FND  = 11'b10000000000
	} state_t;
endpackage

// ===== hdl/bfs_shortest_path_core.sv =====
// Breadth-first shortest path core: edge store, search sequencer, path output.
// Depends on bsp_pkg.
//
// Usage: edge items (kind 0) on the input channel append an undirected edge to
// the edge store; a run item (kind 1) searches from the start vertex to the
// finish vertex and returns the path, one vertex per output transfer, start
// first, with last set on the final one. An unreachable finish, a bad start or
// finish, or a path over 32 vertices gives one result with found low.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do
// so only while idle, as the block does not enforce it. A run dequeues each
// vertex (DEQ, DEQ_W, SCAN), then reads each stored edge from the single-port
// edge memory and checks it in both directions (CHK_FWD, CHK_REV), then
// traces the path vertex by vertex and emits one result per path vertex.
// in_stall is high from the accepted run item until its last result is loaded
// into the output register; the next item may be taken while that result
// still waits. A stalled output holds its result and pauses the sequencer.
// Reset clears the edge count, visited marks, drop flag and output valid;
// memories are not cleared.
module bfs_shortest_path_core #(
	parameter int MAX_NODES = 32,
	parameter int MAX_EDGES = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic [bsp_pkg::VTX_W-1:0]    end_a,
	input  logic [bsp_pkg::VTX_W-1:0]    end_b,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic [bsp_pkg::HOP_W-1:0]    hop_count,
	output logic [bsp_pkg::VTX_W-1:0]    vertex,
	output logic                         last,
	output logic                         dropped,
	input  logic                         cfg_we,
	input  logic [bsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsp_pkg::VTX_W-1:0]    cfg_data
);
	localparam int VW = $clog2(MAX_NODES + 1);        // vertex index bits
	localparam int QW = $clog2(MAX_NODES);            // queue index bits
	localparam int EW = $clog2(MAX_EDGES + 1);        // edge count bits
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int V  = bsp_pkg::VTX_W;

	// memories
	logic [2*V-1:0] edge_mem [MAX_EDGES];
	logic [V-1:0]   pred_mem [MAX_NODES + 1];
	logic [V-1:0]   queue_mem [MAX_NODES];
	logic [V-1:0]   stack_mem [bsp_pkg::PATH_LIMIT];

	logic [2*V-1:0] edge_rd_q;
	logic [V-1:0]   pred_rd_q;
	logic [V-1:0]   queue_rd_q;
	logic [V-1:0]   stack_rd_q;

	bsp_pkg::state_t state_q;
	logic [V-1:0]    node_count_q, start_q, finish_q;
	logic [EW-1:0]   edge_cnt_q, e_q;
	logic [MAX_NODES:0] visited_q;
	logic [VW-1:0]   head_q, tail_q;
	logic [V-1:0]    v_q, w_q;
	logic [V:0]      len_q;
	logic [bsp_pkg::STK_W-1:0] idx_q;
	logic            drop_q, drp_q;

	logic            out_valid_q, found_q, last_q, dropped_q;
	logic [bsp_pkg::HOP_W-1:0] hop_q;
	logic [V-1:0]    vertex_q;

	logic [V-1:0]    n_eff;
	logic            in_xfer, out_free, out_load;
	logic            a_ok, b_ok, s_ok, f_ok;
	logic [V-1:0]    ex, ey;
	logic            disc_en;
	logic [V-1:0]    disc_w;
	logic [EW-1:0]   e_next;
	logic [AW-1:0]   edge_ra;

	assign n_eff = (node_count_q > V'(MAX_NODES)) ? V'(MAX_NODES) : node_count_q;
	assign in_stall = (state_q != bsp_pkg::ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free
		&& (state_q == bsp_pkg::ST_EMIT_WR || state_q == bsp_pkg::ST_NOT_FND);

	assign a_ok = (end_a != '0) && (end_a <= n_eff);
	assign b_ok = (end_b != '0) && (end_b <= n_eff);
	assign s_ok = (start_q != '0) && (start_q <= n_eff);
	assign f_ok = (finish_q != '0) && (finish_q <= n_eff);

	assign ex = edge_rd_q[2*V-1:V];
	assign ey = edge_rd_q[V-1:0];
	assign e_next = e_q + EW'(1);
	assign edge_ra = (state_q == bsp_pkg::ST_CHK_REV) ? e_next[AW-1:0] : e_q[AW-1:0];

	// discovery: forward direction (x == v finds y), then reverse (y == v finds x)
	always_comb begin
		disc_en = 1'b0;
		disc_w  = ey;
		if (state_q == bsp_pkg::ST_CHK_FWD) begin
			disc_en = (ex == v_q) && !visited_q[ey[VW-1:0]];
			disc_w  = ey;
		end else if (state_q == bsp_pkg::ST_CHK_REV) begin
			disc_en = (ey == v_q) && !visited_q[ex[VW-1:0]];
			disc_w  = ex;
		end
	end

	// edge store
	always_ff @(posedge clk) begin
		if (state_q == bsp_pkg::ST_IDLE && in_xfer && kind == bsp_pkg::KIND_EDGE
				&& a_ok && b_ok && edge_cnt_q < EW'(MAX_EDGES))
			edge_mem[edge_cnt_q[AW-1:0]] <= {end_a, end_b};
		if (state_q == bsp_pkg::ST_SCAN || state_q == bsp_pkg::ST_CHK_REV)
			edge_rd_q <= edge_mem[edge_ra];
	end

	// predecessor and queue
	always_ff @(posedge clk) begin
		if (state_q == bsp_pkg::ST_IDLE && in_xfer && kind == bsp_pkg::KIND_RUN) begin
			pred_mem[start_q[VW-1:0]] <= start_q;
			queue_mem[0] <= start_q;
		end else if (disc_en) begin
			pred_mem[disc_w[VW-1:0]] <= v_q;
			if (tail_q < VW'(MAX_NODES))
				queue_mem[tail_q[QW-1:0]] <= disc_w;
		end
		if (state_q == bsp_pkg::ST_TRACE_RD)
			pred_rd_q <= pred_mem[w_q[VW-1:0]];
		if (state_q == bsp_pkg::ST_DEQ)
			queue_rd_q <= queue_mem[head_q[QW-1:0]];
	end

	// path stack
	always_ff @(posedge clk) begin
		if (state_q == bsp_pkg::ST_IDLE && in_xfer && kind == bsp_pkg::KIND_RUN)
			stack_mem[0] <= start_q;
		else if (disc_en && disc_w == finish_q)
			stack_mem[0] <= finish_q;
		else if (state_q == bsp_pkg::ST_TRACE_WR && len_q < (V+1)'(bsp_pkg::PATH_LIMIT))
			stack_mem[len_q[bsp_pkg::STK_W-1:0]] <= pred_rd_q;
		if (state_q == bsp_pkg::ST_EMIT_RD)
			stack_rd_q <= stack_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bsp_pkg::ST_IDLE;
			node_count_q <= V'(32);
			start_q      <= V'(1);
			finish_q     <= V'(1);
			edge_cnt_q   <= '0;
			e_q          <= '0;
			visited_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			v_q          <= '0;
			w_q          <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			drop_q       <= 1'b0;
			drp_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (bsp_pkg::cfg_reg_t'(cfg_index))
					bsp_pkg::REG_NODE_COUNT: node_count_q <= cfg_data;
					bsp_pkg::REG_START:      start_q <= cfg_data;
					bsp_pkg::REG_FINISH:     finish_q <= cfg_data;
					bsp_pkg::REG_UNUSED:     ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (disc_en) begin
				visited_q[disc_w[VW-1:0]] <= 1'b1;
				if (tail_q < VW'(MAX_NODES))
					tail_q <= tail_q + VW'(1);
			end

			unique case (state_q)
				bsp_pkg::ST_IDLE: begin
					if (in_xfer) begin
						if (kind == bsp_pkg::KIND_EDGE) begin
							if (a_ok && b_ok && edge_cnt_q < EW'(MAX_EDGES))
								edge_cnt_q <= edge_cnt_q + EW'(1);
							else
								drop_q <= 1'b1;
						end else begin
							drp_q  <= drop_q;
							drop_q <= 1'b0;
							if (!(s_ok && f_ok)) begin
								visited_q <= '0;
								len_q     <= '0;
								state_q   <= bsp_pkg::ST_NOT_FND;
							end else if (start_q == finish_q) begin
								visited_q <= '0;
								len_q     <= (V+1)'(1);
								idx_q     <= '0;
								state_q   <= bsp_pkg::ST_EMIT_RD;
							end else begin
								visited_q <= (MAX_NODES+1)'(1) << start_q[VW-1:0];
								len_q     <= '0;
								head_q    <= '0;
								tail_q    <= VW'(1);
								state_q   <= bsp_pkg::ST_DEQ;
							end
						end
					end
				end
				bsp_pkg::ST_DEQ: begin
					if (head_q == tail_q) begin
						state_q <= bsp_pkg::ST_NOT_FND;
					end else begin
						head_q  <= head_q + VW'(1);
						state_q <= bsp_pkg::ST_DEQ_W;
					end
				end
				bsp_pkg::ST_DEQ_W: begin
					v_q     <= queue_rd_q;
					e_q     <= '0;
					state_q <= bsp_pkg::ST_SCAN;
				end
				bsp_pkg::ST_SCAN: begin
					if (e_q == edge_cnt_q)
						state_q <= bsp_pkg::ST_DEQ;
					else
						state_q <= bsp_pkg::ST_CHK_FWD;
				end
				bsp_pkg::ST_CHK_FWD, bsp_pkg::ST_CHK_REV: begin
					if (disc_en && disc_w == finish_q) begin
						w_q     <= finish_q;
						len_q   <= (V+1)'(1);
						state_q <= bsp_pkg::ST_TRACE_RD;
					end else if (state_q == bsp_pkg::ST_CHK_FWD) begin
						state_q <= bsp_pkg::ST_CHK_REV;
					end else begin
						e_q <= e_next;
						if (e_next < edge_cnt_q)
							state_q <= bsp_pkg::ST_CHK_FWD;
						else
							state_q <= bsp_pkg::ST_DEQ;
					end
				end
				bsp_pkg::ST_TRACE_RD: begin
					if (w_q == start_q) begin
						idx_q   <= bsp_pkg::STK_W'(len_q - (V+1)'(1));
						state_q <= bsp_pkg::ST_EMIT_RD;
					end else begin
						state_q <= bsp_pkg::ST_TRACE_WR;
					end
				end
				bsp_pkg::ST_TRACE_WR: begin
					if (len_q >= (V+1)'(bsp_pkg::PATH_LIMIT)) begin
						// path longer than the result limit
						len_q   <= '0;
						state_q <= bsp_pkg::ST_NOT_FND;
					end else begin
						w_q     <= pred_rd_q;
						len_q   <= len_q + (V+1)'(1);
						state_q <= bsp_pkg::ST_TRACE_RD;
					end
				end
				bsp_pkg::ST_EMIT_RD: begin
					state_q <= bsp_pkg::ST_EMIT_WR;
				end
				bsp_pkg::ST_EMIT_WR: begin
					if (out_free) begin
						if (idx_q == '0) begin
							edge_cnt_q <= '0;
							state_q    <= bsp_pkg::ST_IDLE;
						end else begin
							idx_q   <= idx_q - bsp_pkg::STK_W'(1);
							state_q <= bsp_pkg::ST_EMIT_RD;
						end
					end
				end
				bsp_pkg::ST_NOT_FND: begin
					if (out_free) begin
						edge_cnt_q  <= '0;
						state_q     <= bsp_pkg::ST_IDLE;
					end
				end
				default: state_q <= bsp_pkg::ST_IDLE;
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == bsp_pkg::ST_EMIT_WR && out_free) begin
			found_q   <= 1'b1;
			hop_q     <= bsp_pkg::HOP_W'(len_q - (V+1)'(1));
			vertex_q  <= stack_rd_q;
			last_q    <= (idx_q == '0);
			dropped_q <= drp_q;
		end else if (state_q == bsp_pkg::ST_NOT_FND && out_free) begin
			found_q   <= 1'b0;
			hop_q     <= '0;
			vertex_q  <= '0;
			last_q    <= 1'b1;
			dropped_q <= drp_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign hop_count = hop_q;
	assign vertex    = vertex_q;
	assign last      = last_q;
	assign dropped   = dropped_q;
endmodule

// ===== hdl/bsp_checker.sv =====
// Port-level checker for the shortest-path search core, bound to its top level.
// Depends on bsp_pkg and bfs_shortest_path_core_assert.svh.
`include "bfs_shortest_path_core_assert.svh"

module bsp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          kind,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          found,
	input logic [bsp_pkg::HOP_W-1:0]     hop_count,
	input logic [bsp_pkg::VTX_W-1:0]     vertex,
	input logic                          last
);
	`BSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(found) && $stable(vertex) && $stable(last),
		"stalled result changed")

	`BSP_ASSERT_NOW(a_not_found_clean, out_valid && !found,
		last && hop_count == '0 && vertex == '0, "not-found result malformed")

	`BSP_ASSERT_NOW(a_zero_hop_last, out_valid && found && hop_count == '0,
		last, "zero-hop path not single")

	`BSP_ASSERT_NEXT(a_run_busy, in_valid && !in_stall && kind == bsp_pkg::KIND_RUN,
		in_stall, "input not stalled during a run")
endmodule

bind bfs_shortest_path_core bsp_checker u_bsp_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the breadth-first shortest path core.
// Depends on bsp_pkg and bfs_shortest_path_core; a predictor inside works out each path.
// Directed graphs, a full edge store, back-pressure and random graphs are run in turn.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       found;
		logic [4:0] hops;
		logic [5:0] vtx;
		logic       last;
		logic       drp;
	} path_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = bsp_pkg::KIND_EDGE;
	logic [bsp_pkg::VTX_W-1:0] end_a = '0;
	logic [bsp_pkg::VTX_W-1:0] end_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic found;
	logic [bsp_pkg::HOP_W-1:0] hop_count;
	logic [bsp_pkg::VTX_W-1:0] vertex;
	logic last;
	logic dropped;
	logic cfg_we = 1'b0;
	bsp_pkg::cfg_reg_t cfg_index = bsp_pkg::REG_NODE_COUNT;
	logic [bsp_pkg::VTX_W-1:0] cfg_data = '0;

	// predictor state
	int unsigned node_cnt = 32;
	int unsigned start_v = 1;
	int unsigned finish_v = 1;
	logic [5:0] edge_a [128];
	logic [5:0] edge_b [128];
	int unsigned edge_cnt = 0;
	bit drop_seen = 0;
	path_step_t path_q[$];

	int errors = 0;
	int unsigned cycles = 0;
	int burst_left = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int stall_mode = 0;

	bfs_shortest_path_core uut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > 1500000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver stall pattern, with an on-demand long hold
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (cycles % 96 == 0)
			stall_mode = $urandom_range(0, 2);
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_mode == 0) begin
			out_stall <= 1'b0;
		end else if (stall_mode == 1) begin
			out_stall <= ($urandom_range(0, 1) == 0);
		end else begin
			out_stall <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		path_step_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{found, hop_count, vertex, last, dropped};
			if (path_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: f=%0d h=%0d v=%0d l=%0d d=%0d",
						found, hop_count, vertex, last, dropped);
			end else begin
				want = path_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: exp f=%0d h=%0d v=%0d l=%0d d=%0d,",
							" got f=%0d h=%0d v=%0d l=%0d d=%0d"},
							want.found, want.hops, want.vtx, want.last, want.drp,
							found, hop_count, vertex, last, dropped);
				end
			end
		end
	end

	function automatic int unsigned eff_nodes();
		return node_cnt > 32 ? 32 : node_cnt;
	endfunction

	task automatic predict_run();
		int unsigned n, head, tail, len;
		logic [5:0] v, w;
		bit vis [34];
		logic [5:0] pred [34];
		logic [5:0] bfs_q [34];
		logic [5:0] stk [34];
		bit hit;
		path_step_t r;
		n = eff_nodes();
		len = 0;
		hit = 0;
		foreach (vis[i]) vis[i] = 0;
		if (start_v >= 1 && start_v <= n && finish_v >= 1 && finish_v <= n) begin
			if (start_v == finish_v) begin
				stk[0] = 6'(start_v);
				len = 1;
			end else begin
				vis[start_v] = 1;
				pred[start_v] = 6'(start_v);
				bfs_q[0] = 6'(start_v);
				head = 0;
				tail = 1;
				while (head < tail && !hit) begin
					v = bfs_q[head];
					head++;
					for (int e = 0; e < edge_cnt && !hit; e++) begin
						if (edge_a[e] == v && !vis[edge_b[e]]) begin
							vis[edge_b[e]] = 1;
							pred[edge_b[e]] = v;
							if (tail <= 32) bfs_q[tail++] = edge_b[e];
							hit = (edge_b[e] == finish_v);
						end
						if (!hit && edge_b[e] == v && !vis[edge_a[e]]) begin
							vis[edge_a[e]] = 1;
							pred[edge_a[e]] = v;
							if (tail <= 32) bfs_q[tail++] = edge_a[e];
							hit = (edge_a[e] == finish_v);
						end
					end
				end
				if (hit) begin
					w = 6'(finish_v);
					stk[len++] = w;
					while (w != start_v && len <= 32) begin
						w = pred[w];
						stk[len++] = w;
					end
				end
			end
		end
		if (len == 0 || len > bsp_pkg::PATH_LIMIT) begin
			r = '{1'b0, 5'd0, 6'd0, 1'b1, drop_seen};
			path_q.push_back(r);
		end else begin
			for (int k = 0; k < len; k++) begin
				r = '{1'b1, 5'(len - 1), stk[len - 1 - k], k == len - 1, drop_seen};
				path_q.push_back(r);
			end
		end
		edge_cnt = 0;
		drop_seen = 0;
	endtask

	// drive one item at the current edge and return on its transfer
	task automatic send_item(logic k, logic [5:0] a, logic [5:0] b);
		int unsigned n;
		in_valid <= 1'b1;
		kind <= k;
		end_a <= a;
		end_b <= b;
		do @(posedge clk); while (in_stall);
		n = eff_nodes();
		if (k == bsp_pkg::KIND_RUN) begin
			predict_run();
		end else if (a < 1 || a > n || b < 1 || b > n || edge_cnt >= 128) begin
			drop_seen = 1;
		end else begin
			edge_a[edge_cnt] = a;
			edge_b[edge_cnt] = b;
			edge_cnt++;
		end
		// bursts with random gaps between them
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (path_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(bsp_pkg::cfg_reg_t idx, logic [5:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			bsp_pkg::REG_NODE_COUNT: node_cnt = val;
			bsp_pkg::REG_START:      start_v = val;
			bsp_pkg::REG_FINISH:     finish_v = val;
			default: ;
		endcase
	endtask

	task automatic setup(logic [5:0] n, logic [5:0] s, logic [5:0] f);
		write_reg(bsp_pkg::REG_NODE_COUNT, n);
		write_reg(bsp_pkg::REG_START, s);
		write_reg(bsp_pkg::REG_FINISH, f);
	endtask

	task automatic test_directed();
		// empty store, start equals finish
		send_item(bsp_pkg::KIND_RUN, 6'd0, 6'd0);
		// chain to the top vertex, plus bad endpoints
		setup(6'd32, 6'd1, 6'd32);
		send_item(bsp_pkg::KIND_EDGE, 6'd1, 6'd2);
		send_item(bsp_pkg::KIND_EDGE, 6'd0, 6'd5);
		send_item(bsp_pkg::KIND_EDGE, 6'd3, 6'd2);
		send_item(bsp_pkg::KIND_EDGE, 6'd33, 6'd1);
		send_item(bsp_pkg::KIND_EDGE, 6'd63, 6'd63);
		send_item(bsp_pkg::KIND_EDGE, 6'd3, 6'd32);
		send_item(bsp_pkg::KIND_RUN, 6'd63, 6'd63);
		// self loop, duplicate, unreachable finish
		setup(6'd8, 6'd2, 6'd7);
		send_item(bsp_pkg::KIND_EDGE, 6'd2, 6'd2);
		send_item(bsp_pkg::KIND_EDGE, 6'd2, 6'd3);
		send_item(bsp_pkg::KIND_EDGE, 6'd2, 6'd3);
		send_item(bsp_pkg::KIND_EDGE, 6'd9, 6'd7);
		send_item(bsp_pkg::KIND_RUN, 6'd0, 6'd0);
		// bad start equal to finish
		setup(6'd4, 6'd5, 6'd5);
		send_item(bsp_pkg::KIND_RUN, 6'd0, 6'd0);
		// zero node count drops everything
		setup(6'd0, 6'd1, 6'd1);
		send_item(bsp_pkg::KIND_EDGE, 6'd1, 6'd1);
		send_item(bsp_pkg::KIND_RUN, 6'd0, 6'd0);
		// node count above the limit acts as the limit
		setup(6'd63, 6'd32, 6'd1);
		send_item(bsp_pkg::KIND_EDGE, 6'd32, 6'd16);
		send_item(bsp_pkg::KIND_EDGE, 6'd1, 6'd16);
		send_item(bsp_pkg::KIND_RUN, 6'd0, 6'd0);
		setup(6'd1, 6'd0, 6'd1);
		send_item(bsp_pkg::KIND_RUN, 6'd0, 6'd0);
	endtask

	task automatic test_store_full();
		setup(6'd32, 6'd1, 6'd32);
		for (int i = 0; i < 130; i++)
			send_item(bsp_pkg::KIND_EDGE, 6'(1 + i % 31), 6'(2 + i % 31));
		send_item(bsp_pkg::KIND_RUN, 6'd0, 6'd0);
	endtask

	task automatic test_backpressure();
		setup(6'd10, 6'd1, 6'd7);
		for (int i = 1; i < 7; i++) send_item(bsp_pkg::KIND_EDGE, 6'(i), 6'(i + 1));
		drain();
		hold_req = 1;
		send_item(bsp_pkg::KIND_RUN, 6'd0, 6'd0);
		for (int i = 1; i < 6; i++) send_item(bsp_pkg::KIND_EDGE, 6'(i + 1), 6'(i));
		send_item(bsp_pkg::KIND_RUN, 6'd0, 6'd0);
		drain();
	endtask

	task automatic test_random();
		int items, ne, n;
		logic [5:0] a, b;
		items = 0;
		while (items < 16) begin
			case ($urandom_range(0, 9))
				0: n = 0;
				1: n = $urandom_range(33, 63);
				2: n = 32;
				default: n = $urandom_range(2, 16);
			endcase
			if ($urandom_range(0, 7) == 0)
				setup(6'(n), 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			else
				setup(6'(n), 6'($urandom_range(1, n < 1 ? 1 : n)),
					6'($urandom_range(1, n < 1 ? 1 : n)));
			ne = $urandom_range(0, 12);
			for (int i = 0; i < ne; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					a = 6'($urandom_range(0, 63));
					b = 6'($urandom_range(0, 63));
				end else begin
					a = 6'($urandom_range(1, n < 1 ? 1 : (n > 32 ? 32 : n)));
					b = 6'($urandom_range(1, n < 1 ? 1 : (n > 32 ? 32 : n)));
				end
				send_item(bsp_pkg::KIND_EDGE, a, b);
			end
			send_item(bsp_pkg::KIND_RUN, 6'($urandom_range(0, 63)),
				6'($urandom_range(0, 63)));
			items += ne + 1;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_store_full();
		test_backpressure();
		test_random();
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && path_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
